[src/pcs_pkg.sv]
// pcs_pkg: shared constants and controller/datapath interface types
// for the puct child selection block; no dependencies
package pcs_pkg;

  localparam int unsigned MaxChildrenDef = 1024;
  localparam logic [23:0] ExploreWeightRst = 24'd6554;
  localparam logic [16:0] OneQ16 = 17'd65536;

  localparam int unsigned DivBits = 2;
  localparam int unsigned SqrtBits = 2;
  localparam int unsigned DivCycles = 64 / DivBits;
  localparam int unsigned SqrtCycles = 32 / SqrtBits;
  localparam int unsigned MeanSteps = 17;
  localparam int unsigned StepW = 5;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mean_step;
    logic sqrt_step;
    logic mul;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic out_free;
  } sts_t;

endpackage

[src/pcs_ctrl.sv]
// pcs_ctrl: sequencer for one child word, drives divider, root and score steps
// depends on pcs_pkg
module pcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pcs_pkg::sts_t sts_i,
  output pcs_pkg::cmd_t cmd_o
);
  import pcs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = sts_i.skip ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.mean_step = (step_q < StepW'(MeanSteps));
        if (step_q == StepW'(DivCycles - 1)) begin
          step_d  = '0;
          state_d = S_SQRT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (step_q == StepW'(SqrtCycles - 1)) begin
          step_d  = '0;
          state_d = S_MUL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.last || sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.div_step, cmd_o.sqrt_step, cmd_o.mul, cmd_o.finish}))
    else $error("more than one datapath command");
  a_div_to_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && step_q == StepW'(DivCycles - 1)) |=> (state_q == S_SQRT))
    else $error("divider did not hand over to square root");
`endif

endmodule

[src/pcs_dp.sv]
// pcs_dp: mean and ratio dividers, square root, score multiply and best tracking
// depends on pcs_pkg
module pcs_dp #(
  parameter int unsigned MAX_CHILDREN = pcs_pkg::MaxChildrenDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcs_pkg::cmd_t cmd_i,
  output pcs_pkg::sts_t sts_o,
  input  logic [31:0]   child_visits_i,
  input  logic [47:0]   child_value_sum_i,
  input  logic [16:0]   child_prior_i,
  input  logic [31:0]   parent_visits_i,
  input  logic          last_child_i,
  input  logic          cfg_we_i,
  input  logic [23:0]   cfg_wdata_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [9:0]    best_child_o
);
  import pcs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_CHILDREN + 1);
  localparam int unsigned IdxW = $clog2(MAX_CHILDREN);

  logic [23:0]     ew_q;
  logic [31:0]     visits_q;
  logic [32:0]     dvs_q;
  logic [16:0]     prior_q;
  logic            vz_q, pz_q, last_q, skip_q;
  logic [63:0]     num_q, num_div, num_sqrt;
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     mrem_q, mrem_d;
  logic [16:0]     mnum_q, mnum_d;
  logic            msat_q;
  logic [31:0]     sroot_q, sroot_d;
  logic [33:0]     srem_q, srem_d;
  logic [24:0]     cp_q;
  logic [40:0]     expl_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] best_idx_q, new_idx;
  logic [47:0]     best_score_q, score;
  logic            have_best_q, wins;
  logic            out_valid_q;
  logic [9:0]      best_child_q;
  logic [40:0]     cp_prod;
  logic [56:0]     ex_prod;
  logic [31:0]     factor;
  logic [16:0]     mean;
  logic [IdxW+9:0] widx;

  always_comb begin
    logic [32:0] r;
    logic [63:0] n;
    logic [33:0] t;
    r = rem_q;
    n = num_q;
    for (int i = 0; i < int'(DivBits); i++) begin
      t = {r, n[63]};
      n = {n[62:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        t    = t - {1'b0, dvs_q};
        n[0] = 1'b1;
      end
      r = t[32:0];
    end
    rem_d   = r;
    num_div = n;
  end

  always_comb begin
    logic [32:0] t;
    t      = {mrem_q, mnum_q[16]};
    mnum_d = {mnum_q[15:0], 1'b0};
    if (t >= {1'b0, visits_q}) begin
      t         = t - {1'b0, visits_q};
      mnum_d[0] = 1'b1;
    end
    mrem_d = t[31:0];
  end

  always_comb begin
    logic [33:0] s;
    logic [33:0] trial;
    logic [31:0] rt;
    logic [63:0] n;
    s  = srem_q;
    rt = sroot_q;
    n  = num_q;
    for (int i = 0; i < int'(SqrtBits); i++) begin
      s     = {s[31:0], n[63:62]};
      n     = {n[61:0], 2'b00};
      trial = {rt, 2'b01};
      if (s >= trial) begin
        s  = s - trial;
        rt = {rt[30:0], 1'b1};
      end else begin
        rt = {rt[30:0], 1'b0};
      end
    end
    srem_d   = s;
    sroot_d  = rt;
    num_sqrt = n;
  end

  assign cp_prod = {17'd0, ew_q} * {24'd0, prior_q};
  assign factor  = pz_q ? {15'd0, OneQ16} : sroot_q;
  assign ex_prod = {32'd0, cp_q} * {25'd0, factor};

  always_comb begin
    if (vz_q) begin
      mean = '0;
    end else if (msat_q || mnum_q > OneQ16) begin
      mean = OneQ16;
    end else begin
      mean = mnum_q;
    end
  end

  assign score   = {31'd0, mean} + {7'd0, expl_q};
  assign wins    = !skip_q && (!have_best_q || score > best_score_q);
  assign new_idx = wins ? cnt_q[IdxW-1:0] : best_idx_q;
  assign widx    = {10'd0, new_idx};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      visits_q <= child_visits_i;
      dvs_q    <= {1'b0, child_visits_i} + 33'd1;
      prior_q  <= child_prior_i;
      vz_q     <= (child_visits_i == 32'd0);
      pz_q     <= (parent_visits_i == 32'd0);
      last_q   <= last_child_i;
      skip_q   <= (cnt_q >= CntW'(MAX_CHILDREN));
      num_q    <= {parent_visits_i, 32'd0};
      rem_q    <= '0;
      mrem_q   <= {1'b0, child_value_sum_i[47:17]};
      mnum_q   <= child_value_sum_i[16:0];
      msat_q   <= ({1'b0, child_value_sum_i[47:17]} >= child_visits_i);
      srem_q   <= '0;
      sroot_q  <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= num_div;
      rem_q <= rem_d;
      cp_q  <= cp_prod[40:16];
    end
    if (cmd_i.mean_step) begin
      mrem_q <= mrem_d;
      mnum_q <= mnum_d;
    end
    if (cmd_i.sqrt_step) begin
      num_q   <= num_sqrt;
      srem_q  <= srem_d;
      sroot_q <= sroot_d;
    end
    if (cmd_i.mul) begin
      expl_q <= ex_prod[56:16];
    end
    if (cmd_i.finish && last_q) begin
      best_child_q <= widx[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ew_q         <= ExploreWeightRst;
      cnt_q        <= '0;
      best_idx_q   <= '0;
      best_score_q <= '0;
      have_best_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ew_q <= cfg_wdata_i;
      end
      if (cmd_i.finish && last_q) begin
        cnt_q        <= '0;
        best_idx_q   <= '0;
        best_score_q <= '0;
        have_best_q  <= 1'b0;
      end else if (cmd_i.finish && !skip_q) begin
        cnt_q       <= cnt_q + 1'b1;
        have_best_q <= 1'b1;
        if (wins) begin
          best_idx_q   <= cnt_q[IdxW-1:0];
          best_score_q <= score;
        end
      end
      if (cmd_i.finish && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.skip     = (cnt_q >= CntW'(MAX_CHILDREN));
  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign best_child_o   = best_child_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_CHILDREN))
    else $error("child counter beyond limit");
  a_node_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && last_q) |=> (out_valid_q && !have_best_q && cnt_q == '0))
    else $error("node end did not post word and clear state");
`endif

endmodule

[src/puct_child_select.sv]
// puct_child_select: one child word accepted at a time; a scored child goes, from its
// acceptance to the earliest next one, through the accept step, the radix-4 ratio
// divider, the radix-4 square root, one multiply and one score compare. a child past
// the list limit goes straight to the score compare. the result word is registered at
// the last child's compare, which waits while the output register is full and unread.
// asynchronous active-low reset clears all control state, explore weight to 6554
module puct_child_select #(
  parameter int unsigned MAX_CHILDREN = pcs_pkg::MaxChildrenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] child_visits_i,
  input  logic [47:0] child_value_sum_i,
  input  logic [16:0] child_prior_i,
  input  logic [31:0] parent_visits_i,
  input  logic        last_child_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  best_child_o
);
  import pcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcs_dp #(
    .MAX_CHILDREN (MAX_CHILDREN)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .child_visits_i    (child_visits_i),
    .child_value_sum_i (child_value_sum_i),
    .child_prior_i     (child_prior_i),
    .parent_visits_i   (parent_visits_i),
    .last_child_i      (last_child_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .best_child_o      (best_child_o)
  );

endmodule
